### design/rpsc_pkg.sv
// Shared types and constants for the receive packet steering classifier.
`timescale 1ns / 1ps
`default_nettype none
package rpsc_pkg;

  // Ethertypes, protocols and well-known ports.
  localparam logic [15:0] ETH_IPV4      = 16'h0800;
  localparam logic [15:0] ETH_ARP       = 16'h0806;
  localparam logic [15:0] ETH_IPV6      = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
  localparam logic [15:0] PORT_DNS      = 16'd53;
  localparam logic [15:0] PORT_DHCP_SRV = 16'd67;
  localparam logic [15:0] PORT_DHCP_CLI = 16'd68;

  // Direction codes.
  localparam logic [1:0] DIR_DISCARD = 2'd0;
  localparam logic [1:0] DIR_UP      = 2'd1;
  localparam logic [1:0] DIR_BOTH    = 2'd3;

  // Rule mask bit positions.
  localparam int MASK_IFACE = 0;
  localparam int MASK_SIP   = 1;
  localparam int MASK_DIP   = 2;
  localparam int MASK_SPORT = 3;
  localparam int MASK_DPORT = 4;
  localparam int MASK_PROTO = 5;

  // Configuration register indexes (byte address / 4).
  localparam logic [2:0] REG_DEFAULT_DIR = 3'd0;
  localparam logic [2:0] REG_HOST_READY  = 3'd1;
  localparam logic [2:0] REG_BRIDGE_MODE = 3'd2;
  localparam logic [2:0] REG_RULES_USED  = 3'd3;
  localparam logic [2:0] REG_STA_PORT    = 3'd4;
  localparam logic [2:0] REG_AP_PORT     = 3'd5;

  // Depth of the queue between front and back; keep it a power of two.
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0] default_dir;
    logic       host_ready;
    logic       bridge_mode;
    logic [4:0] rules_in_use;
    logic       sta_port;
    logic       ap_port;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_SCAN  = 2'd2
  } kind_e;

  // One queued request: a rule write, a settled frame, or a frame key to scan.
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  dir;
    logic [3:0]  slot;
    logic [5:0]  mask;
    logic        iface;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] sip;
    logic [31:0] dip;
  } qent_t;

  typedef struct packed {
    logic [5:0]  mask;
    logic [1:0]  dir;
    logic        iface;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] sip;
    logic [31:0] dip;
  } rule_t;

endpackage
`default_nettype wire

### design/rpsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rpsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/rpsc_front.sv
// Front decoder: masks header fields, settles the fixed steering cases and passes rule writes on.
`timescale 1ns / 1ps
`default_nettype none
module rpsc_front (
  input  wire logic               command_i,
  input  wire logic [3:0]         rule_slot_i,
  input  wire logic [5:0]         rule_mask_i,
  input  wire logic [1:0]         rule_direction_i,
  input  wire logic [15:0]        ethertype_i,
  input  wire logic [7:0]         ip_proto_i,
  input  wire logic [15:0]        l4_sport_i,
  input  wire logic [15:0]        l4_dport_i,
  input  wire logic [31:0]        src_ip_i,
  input  wire logic [31:0]        dst_ip_i,
  input  wire logic               rx_iface_i,
  input  wire logic [7:0]         icmp_kind_i,
  input  wire rpsc_pkg::cfg_t     cfg_i,
  output rpsc_pkg::qent_t         ent_o
);

  logic        is_v4;
  logic        is_arp;
  logic        is_l4;
  logic [7:0]  pr;
  logic [15:0] sp;
  logic [15:0] dp;
  logic [31:0] sip;
  logic [31:0] dip;

  always_comb begin
    is_v4  = (ethertype_i == rpsc_pkg::ETH_IPV4);
    is_arp = (ethertype_i == rpsc_pkg::ETH_ARP);
    pr     = is_v4 ? ip_proto_i : 8'd0;
    is_l4  = is_v4 && (pr == rpsc_pkg::PROTO_TCP || pr == rpsc_pkg::PROTO_UDP);
    sp     = is_l4 ? l4_sport_i : 16'd0;
    dp     = is_l4 ? l4_dport_i : 16'd0;
    sip    = (is_v4 || is_arp) ? src_ip_i : 32'd0;
    dip    = (is_v4 || is_arp) ? dst_ip_i : 32'd0;

    ent_o      = '0;
    ent_o.slot = rule_slot_i;
    ent_o.mask = rule_mask_i;

    if (command_i) begin
      // Rule write carries raw compare values.
      ent_o.kind  = rpsc_pkg::KIND_WRITE;
      ent_o.dir   = rule_direction_i;
      ent_o.iface = rx_iface_i;
      ent_o.proto = ip_proto_i;
      ent_o.sport = l4_sport_i;
      ent_o.dport = l4_dport_i;
      ent_o.sip   = src_ip_i;
      ent_o.dip   = dst_ip_i;
    end else begin
      ent_o.kind  = rpsc_pkg::KIND_DONE;
      ent_o.iface = rx_iface_i;
      ent_o.proto = pr;
      ent_o.sport = sp;
      ent_o.dport = dp;
      ent_o.sip   = sip;
      ent_o.dip   = dip;
      if (ethertype_i == rpsc_pkg::ETH_IPV6) begin
        ent_o.dir = rpsc_pkg::DIR_DISCARD;
      end else if (cfg_i.bridge_mode && !cfg_i.host_ready) begin
        ent_o.dir = rpsc_pkg::DIR_UP;
      end else if (is_arp) begin
        ent_o.dir = rpsc_pkg::DIR_BOTH;
      end else if (pr == rpsc_pkg::PROTO_ICMP) begin
        ent_o.dir = (icmp_kind_i == rpsc_pkg::ICMP_ECHO_REQ) ?
                    rpsc_pkg::DIR_UP : rpsc_pkg::DIR_BOTH;
      end else if (sp == 16'd0 || dp == 16'd0) begin
        ent_o.dir = rpsc_pkg::DIR_BOTH;
      end else if (pr == rpsc_pkg::PROTO_UDP && sp == rpsc_pkg::PORT_DNS) begin
        ent_o.dir = rpsc_pkg::DIR_BOTH;
      end else if (pr == rpsc_pkg::PROTO_UDP && sp == rpsc_pkg::PORT_DHCP_SRV &&
                   rx_iface_i == cfg_i.sta_port) begin
        ent_o.dir = rpsc_pkg::DIR_UP;
      end else if (pr == rpsc_pkg::PROTO_UDP && sp == rpsc_pkg::PORT_DHCP_CLI &&
                   rx_iface_i == cfg_i.ap_port) begin
        ent_o.dir = rpsc_pkg::DIR_UP;
      end else begin
        // No fixed case claims it: the back end searches the rules.
        ent_o.kind = rpsc_pkg::KIND_SCAN;
      end
    end
  end

endmodule
`default_nettype wire

### design/rpsc_queue.sv
// Short FIFO of requests between the front decoder and the rule engine.
`timescale 1ns / 1ps
`default_nettype none
module rpsc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rpsc_pkg::qent_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output rpsc_pkg::qent_t      head_o,
  output logic                 head_valid_o
);

  localparam int PW = (rpsc_pkg::Q_DEPTH > 1) ? $clog2(rpsc_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(rpsc_pkg::Q_DEPTH + 1);

  rpsc_pkg::qent_t mem_q [rpsc_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    full_o       = (count_q == CW'(rpsc_pkg::Q_DEPTH));
    head_valid_o = (count_q != '0);
    head_o       = mem_q[rd_ptr_q];
    do_push      = push_i && !full_o;
    do_pop       = pop_i && head_valid_o;
    wr_ptr_d     = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d     = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d      = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### design/rpsc_back.sv
// Rule engine: applies rule writes, passes on settled frames and scans the rule RAM one slot per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rpsc_back #(
  parameter int RULE_SLOTS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rpsc_pkg::cfg_t  cfg_i,
  input  wire rpsc_pkg::qent_t head_i,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic [1:0]           direction_o,
  output logic                 rule_hit_o,
  output logic [3:0]           hit_slot_o
);

  localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  function automatic logic rule_match(rpsc_pkg::rule_t r, rpsc_pkg::qent_t e);
    logic m;
    m = 1'b1;
    if (r.mask[rpsc_pkg::MASK_IFACE] && r.iface != e.iface) m = 1'b0;
    if (r.mask[rpsc_pkg::MASK_SIP]   && r.sip   != e.sip)   m = 1'b0;
    if (r.mask[rpsc_pkg::MASK_DIP]   && r.dip   != e.dip)   m = 1'b0;
    if (r.mask[rpsc_pkg::MASK_SPORT] && r.sport != e.sport) m = 1'b0;
    if (r.mask[rpsc_pkg::MASK_DPORT] && r.dport != e.dport) m = 1'b0;
    if (r.mask[rpsc_pkg::MASK_PROTO] && r.proto != e.proto) m = 1'b0;
    return m;
  endfunction

  state_e          st_q, st_d;
  rpsc_pkg::qent_t cur_q, cur_d;
  logic [CW-1:0]   rd_idx_q, rd_idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic [AW-1:0]   data_idx_q, data_idx_d;
  logic            res_vld_q, res_vld_d;
  logic [1:0]      res_dir_q, res_dir_d;
  logic            res_hit_q, res_hit_d;
  logic [3:0]      res_slot_q, res_slot_d;
  logic [6:0]      n_eff;
  logic            ram_we;
  logic            ram_re;
  rpsc_pkg::rule_t ram_wdata;
  rpsc_pkg::rule_t ram_rdata;

  always_comb begin
    ram_wdata.mask  = head_i.mask;
    ram_wdata.dir   = head_i.dir;
    ram_wdata.iface = head_i.iface;
    ram_wdata.proto = head_i.proto;
    ram_wdata.sport = head_i.sport;
    ram_wdata.dport = head_i.dport;
    ram_wdata.sip   = head_i.sip;
    ram_wdata.dip   = head_i.dip;

    // Clamp the rule count to the table size.
    n_eff = (7'(cfg_i.rules_in_use) > 7'(RULE_SLOTS)) ?
            7'(RULE_SLOTS) : 7'(cfg_i.rules_in_use);

    st_d       = st_q;
    cur_d      = cur_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    data_idx_d = data_idx_q;
    res_vld_d  = 1'b0;
    res_dir_d  = res_dir_q;
    res_hit_d  = res_hit_q;
    res_slot_d = res_slot_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          case (head_i.kind)
            rpsc_pkg::KIND_WRITE: begin
              // Drop writes to slots beyond the table.
              ram_we = (7'(head_i.slot) < 7'(RULE_SLOTS));
            end
            rpsc_pkg::KIND_DONE: begin
              res_vld_d  = 1'b1;
              res_dir_d  = head_i.dir;
              res_hit_d  = 1'b0;
              res_slot_d = 4'd0;
            end
            rpsc_pkg::KIND_SCAN: begin
              cur_d    = head_i;
              rd_idx_d = '0;
              st_d     = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && rule_match(ram_rdata, cur_q)) begin
          res_vld_d  = 1'b1;
          res_dir_d  = ram_rdata.dir;
          res_hit_d  = 1'b1;
          res_slot_d = 4'(data_idx_q);
          st_d       = ST_IDLE;
        end else if (7'(rd_idx_q) < n_eff) begin
          ram_re     = 1'b1;
          rd_vld_d   = 1'b1;
          data_idx_d = rd_idx_q[AW-1:0];
          rd_idx_d   = rd_idx_q + 1'b1;
        end else begin
          res_vld_d  = 1'b1;
          res_dir_d  = cfg_i.default_dir;
          res_hit_d  = 1'b0;
          res_slot_d = 4'd0;
          st_d       = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    data_idx_q <= data_idx_d;
    res_dir_q  <= res_dir_d;
    res_hit_q  <= res_hit_d;
    res_slot_q <= res_slot_d;
  end

  rpsc_ram #(
    .WIDTH ($bits(rpsc_pkg::rule_t)),
    .DEPTH (RULE_SLOTS)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(head_i.slot)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = res_vld_q;
  assign direction_o    = res_dir_q;
  assign rule_hit_o     = res_hit_q;
  assign hit_slot_o     = res_slot_q;

endmodule
`default_nettype wire

### design/rx_packet_steering_classifier_core.sv
// Top level of the receive packet steering classifier.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Present a request (a frame header or a rule write) with start high; it is
//   taken at a clock edge where start is high and busy is low. busy rises when
//   the two-entry request queue is full.
//   Each frame yields one result on direction_o/rule_hit_o/hit_slot_o, marked
//   by result_valid_o for exactly one cycle; rule writes yield none.
//   The receiver cannot stall, so results never wait.
// Flow:
//   A frame settled by a fixed case, or a rule write, is handled in the
//   rule engine's idle state without a scan; a fixed-case result passes
//   through the request queue and then the engine's result register.
//   A frame that reaches the rule table is checked against slots 0 to N-1 in
//   order, N = min(rules_in_use, RULE_SLOTS), and takes default_dir on a miss:
//   the single read port of the rule RAM yields one slot per cycle.
//   The queue lets the front keep accepting while the engine scans, until full.
// Reset:
//   Clears control state and loads register defaults (bridge mode on, access
//   point on interface 1). The rule table is not cleared: write every slot
//   in use before classifying.
// Config: APB writes at byte address 4*i; the user must write only while no request is pending (not enforced).
module rx_packet_steering_classifier_core #(
  parameter int RULE_SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic [3:0]  rule_slot_i,
  input  wire logic [5:0]  rule_mask_i,
  input  wire logic [1:0]  rule_direction_i,
  input  wire logic [15:0] ethertype_i,
  input  wire logic [7:0]  ip_proto_i,
  input  wire logic [15:0] l4_sport_i,
  input  wire logic [15:0] l4_dport_i,
  input  wire logic [31:0] src_ip_i,
  input  wire logic [31:0] dst_ip_i,
  input  wire logic        rx_iface_i,
  input  wire logic [7:0]  icmp_kind_i,
  // result channel
  output logic             result_valid_o,
  output logic [1:0]       direction_o,
  output logic             rule_hit_o,
  output logic [3:0]       hit_slot_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  rpsc_pkg::cfg_t  cfg_q;
  rpsc_pkg::cfg_t  cfg_d;
  rpsc_pkg::qent_t front_ent;
  rpsc_pkg::qent_t head;
  logic            head_valid;
  logic            pop;
  logic            q_full;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register writes: decode by word index, ignore unknown indexes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[4:2])
        rpsc_pkg::REG_DEFAULT_DIR: cfg_d.default_dir  = pwdata[1:0];
        rpsc_pkg::REG_HOST_READY:  cfg_d.host_ready   = pwdata[0];
        rpsc_pkg::REG_BRIDGE_MODE: cfg_d.bridge_mode  = pwdata[0];
        rpsc_pkg::REG_RULES_USED:  cfg_d.rules_in_use = pwdata[4:0];
        rpsc_pkg::REG_STA_PORT:    cfg_d.sta_port     = pwdata[0];
        rpsc_pkg::REG_AP_PORT:     cfg_d.ap_port      = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_dir  <= 2'd0;
      cfg_q.host_ready   <= 1'b0;
      cfg_q.bridge_mode  <= 1'b1;
      cfg_q.rules_in_use <= 5'd0;
      cfg_q.sta_port     <= 1'b0;
      cfg_q.ap_port      <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[4:2])
      rpsc_pkg::REG_DEFAULT_DIR: prdata = 32'(cfg_q.default_dir);
      rpsc_pkg::REG_HOST_READY:  prdata = 32'(cfg_q.host_ready);
      rpsc_pkg::REG_BRIDGE_MODE: prdata = 32'(cfg_q.bridge_mode);
      rpsc_pkg::REG_RULES_USED:  prdata = 32'(cfg_q.rules_in_use);
      rpsc_pkg::REG_STA_PORT:    prdata = 32'(cfg_q.sta_port);
      rpsc_pkg::REG_AP_PORT:     prdata = 32'(cfg_q.ap_port);
      default:                   prdata = 32'd0;
    endcase
  end

  // Hold off new requests while the queue is full.
  assign busy = q_full;

  rpsc_front u_front (
    .command_i        (command_i),
    .rule_slot_i      (rule_slot_i),
    .rule_mask_i      (rule_mask_i),
    .rule_direction_i (rule_direction_i),
    .ethertype_i      (ethertype_i),
    .ip_proto_i       (ip_proto_i),
    .l4_sport_i       (l4_sport_i),
    .l4_dport_i       (l4_dport_i),
    .src_ip_i         (src_ip_i),
    .dst_ip_i         (dst_ip_i),
    .rx_iface_i       (rx_iface_i),
    .icmp_kind_i      (icmp_kind_i),
    .cfg_i            (cfg_q),
    .ent_o            (front_ent)
  );

  rpsc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (start && !busy),
    .push_data_i  (front_ent),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  rpsc_back #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .direction_o    (direction_o),
    .rule_hit_o     (rule_hit_o),
    .hit_slot_o     (hit_slot_o)
  );

endmodule
`default_nettype wire

### verif/rx_packet_steering_classifier_core_test.sv
// Self-checking testbench for the receive packet steering classifier core.
`timescale 1ns / 1ps
module rx_packet_steering_classifier_core_test;
  import rpsc_pkg::*;

  localparam int RULE_SLOTS     = 16;
  // Worst rule engine time for one frame plus queue slack, in cycles.
  localparam int DRAIN_CYCLES   = 2 * (RULE_SLOTS + 4);
  localparam int DRAIN_LIMIT    = 4000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_REQUESTS = 110;
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_GAP        = 20;

  localparam logic       CMD_CLASSIFY   = 1'b0;
  localparam logic       CMD_RULE_WRITE = 1'b1;
  localparam logic [1:0] DIR_HOST       = 2'd2;

  localparam logic [5:0] MASK_ALL = 6'h3F;
  localparam logic [5:0] MASK_NONE = 6'h00;

  // One request as presented on the input ports.
  typedef struct packed {
    logic        command;
    logic [3:0]  rule_slot;
    logic [5:0]  rule_mask;
    logic [1:0]  rule_direction;
    logic [15:0] ethertype;
    logic [7:0]  ip_proto;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic        rx_iface;
    logic [7:0]  icmp_kind;
  } request_t;

  // Steering decision for one frame.
  typedef struct packed {
    logic [1:0] dir;
    logic       hit;
    logic [3:0] slot;
  } verdict_t;

  // Clock, reset and block inputs, all known from time zero.
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        start            = 1'b0;
  logic        command_i        = CMD_CLASSIFY;
  logic [3:0]  rule_slot_i      = 4'd0;
  logic [5:0]  rule_mask_i      = 6'd0;
  logic [1:0]  rule_direction_i = 2'd0;
  logic [15:0] ethertype_i      = 16'd0;
  logic [7:0]  ip_proto_i       = 8'd0;
  logic [15:0] l4_sport_i       = 16'd0;
  logic [15:0] l4_dport_i       = 16'd0;
  logic [31:0] src_ip_i         = 32'd0;
  logic [31:0] dst_ip_i         = 32'd0;
  logic        rx_iface_i       = 1'b0;
  logic [7:0]  icmp_kind_i      = 8'd0;
  logic        psel             = 1'b0;
  logic        penable          = 1'b0;
  logic        pwrite           = 1'b0;
  logic [4:0]  paddr            = 5'd0;
  logic [31:0] pwdata           = 32'd0;

  logic        busy;
  logic        result_valid_o;
  logic [1:0]  direction_o;
  logic        rule_hit_o;
  logic [3:0]  hit_slot_o;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the block: register settings and rule table.
  cfg_t  steer_cfg = '{default_dir: 2'd0, host_ready: 1'b0, bridge_mode: 1'b1,
                       rules_in_use: 5'd0, sta_port: 1'b0, ap_port: 1'b1};
  rule_t steer_rules [RULE_SLOTS];

  // Decisions still owed by the block, oldest first.
  verdict_t pending_verdicts [$];

  int sender_idle_pct = 0;
  int mismatches      = 0;
  int frames_sent     = 0;
  int rules_sent      = 0;
  int hits_seen       = 0;
  int settings_used   = 0;

  rx_packet_steering_classifier_core #(
    .RULE_SLOTS(RULE_SLOTS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .rule_slot_i     (rule_slot_i),
    .rule_mask_i     (rule_mask_i),
    .rule_direction_i(rule_direction_i),
    .ethertype_i     (ethertype_i),
    .ip_proto_i      (ip_proto_i),
    .l4_sport_i      (l4_sport_i),
    .l4_dport_i      (l4_dport_i),
    .src_ip_i        (src_ip_i),
    .dst_ip_i        (dst_ip_i),
    .rx_iface_i      (rx_iface_i),
    .icmp_kind_i     (icmp_kind_i),
    .result_valid_o  (result_valid_o),
    .direction_o     (direction_o),
    .rule_hit_o      (rule_hit_o),
    .hit_slot_o      (hit_slot_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Steering predictor
  // ---------------------------------------------------------------------

  // A rule matches when every field selected by its mask is equal.
  function automatic logic rule_covers(rule_t r, logic iface, logic [31:0] sip,
                                       logic [31:0] dip, logic [15:0] sp,
                                       logic [15:0] dp, logic [7:0] pr);
    return !((r.mask[MASK_IFACE] && r.iface != iface) ||
             (r.mask[MASK_SIP]   && r.sip   != sip)   ||
             (r.mask[MASK_DIP]   && r.dip   != dip)   ||
             (r.mask[MASK_SPORT] && r.sport != sp)    ||
             (r.mask[MASK_DPORT] && r.dport != dp)    ||
             (r.mask[MASK_PROTO] && r.proto != pr));
  endfunction

  function automatic verdict_t steer_frame(request_t q);
    logic [7:0]  pr;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] sip;
    logic [31:0] dip;
    int          n;
    verdict_t    v;
    pr  = 8'd0;
    sp  = 16'd0;
    dp  = 16'd0;
    sip = 32'd0;
    dip = 32'd0;
    v   = '0;
    // Mask off the header fields that do not apply to this ethertype.
    if (q.ethertype == ETH_IPV4) begin
      pr  = q.ip_proto;
      sip = q.src_ip;
      dip = q.dst_ip;
      if (pr == PROTO_TCP || pr == PROTO_UDP) begin
        sp = q.l4_sport;
        dp = q.l4_dport;
      end
    end else if (q.ethertype == ETH_ARP) begin
      sip = q.src_ip;
      dip = q.dst_ip;
    end
    // Fixed cases first, in priority order; the rule table comes last.
    if (q.ethertype == ETH_IPV6) begin
      v.dir = DIR_DISCARD;
    end else if (steer_cfg.bridge_mode && !steer_cfg.host_ready) begin
      v.dir = DIR_UP;
    end else if (q.ethertype == ETH_ARP) begin
      v.dir = DIR_BOTH;
    end else if (pr == PROTO_ICMP) begin
      v.dir = (q.icmp_kind == ICMP_ECHO_REQ) ? DIR_UP : DIR_BOTH;
    end else if (sp == 16'd0 || dp == 16'd0) begin
      v.dir = DIR_BOTH;
    end else if (pr == PROTO_UDP && sp == PORT_DNS) begin
      v.dir = DIR_BOTH;
    end else if (pr == PROTO_UDP && sp == PORT_DHCP_SRV && q.rx_iface == steer_cfg.sta_port) begin
      v.dir = DIR_UP;
    end else if (pr == PROTO_UDP && sp == PORT_DHCP_CLI && q.rx_iface == steer_cfg.ap_port) begin
      v.dir = DIR_UP;
    end else begin
      v.dir = steer_cfg.default_dir;
      n = (steer_cfg.rules_in_use > RULE_SLOTS) ? RULE_SLOTS : int'(steer_cfg.rules_in_use);
      for (int i = 0; i < n && !v.hit; i++) begin
        if (rule_covers(steer_rules[i], q.rx_iface, sip, dip, sp, dp, pr)) begin
          v.dir  = steer_rules[i].dir;
          v.hit  = 1'b1;
          v.slot = 4'(i);
        end
      end
    end
    return v;
  endfunction

  function automatic logic [31:0] register_value(logic [2:0] idx);
    case (idx)
      REG_DEFAULT_DIR: return {30'd0, steer_cfg.default_dir};
      REG_HOST_READY:  return {31'd0, steer_cfg.host_ready};
      REG_BRIDGE_MODE: return {31'd0, steer_cfg.bridge_mode};
      REG_RULES_USED:  return {27'd0, steer_cfg.rules_in_use};
      REG_STA_PORT:    return {31'd0, steer_cfg.sta_port};
      REG_AP_PORT:     return {31'd0, steer_cfg.ap_port};
      default:         return 32'd0;
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------

  // Rule fields are don't-care on a frame; fill them randomly.
  function automatic request_t make_frame(logic [15:0] eth, logic [7:0] pr,
                                          logic [15:0] sp, logic [15:0] dp,
                                          logic [31:0] sip, logic [31:0] dip,
                                          logic iface, logic [7:0] icmp);
    request_t q;
    q.command        = CMD_CLASSIFY;
    q.rule_slot      = 4'($urandom);
    q.rule_mask      = 6'($urandom);
    q.rule_direction = 2'($urandom);
    q.ethertype      = eth;
    q.ip_proto       = pr;
    q.l4_sport       = sp;
    q.l4_dport       = dp;
    q.src_ip         = sip;
    q.dst_ip         = dip;
    q.rx_iface       = iface;
    q.icmp_kind      = icmp;
    return q;
  endfunction

  function automatic request_t make_rule(logic [3:0] slot, logic [5:0] mask,
                                         logic [1:0] dir, logic [7:0] pr,
                                         logic [15:0] sp, logic [15:0] dp,
                                         logic [31:0] sip, logic [31:0] dip,
                                         logic iface);
    request_t q;
    q = make_frame(16'($urandom), pr, sp, dp, sip, dip, iface, 8'($urandom));
    q.command        = CMD_RULE_WRITE;
    q.rule_slot      = slot;
    q.rule_mask      = mask;
    q.rule_direction = dir;
    return q;
  endfunction

  // Small value pools make random frames collide with random rules.
  function automatic logic [31:0] pool_ip();
    case ($urandom_range(0, 4))
      0:       return 32'h0A00_0001;
      1:       return 32'hC0A8_0101;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pool_port();
    case ($urandom_range(0, 4))
      0:       return 16'd80;
      1:       return 16'd443;
      2:       return 16'hFFFF;
      3:       return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic request_t random_rule(logic [3:0] slot);
    logic [7:0] pr;
    case ($urandom_range(0, 2))
      0:       pr = PROTO_TCP;
      1:       pr = PROTO_UDP;
      default: pr = 8'($urandom);
    endcase
    return make_rule(slot, 6'($urandom), 2'($urandom), pr, pool_port(), pool_port(),
                     pool_ip(), pool_ip(), 1'($urandom));
  endfunction

  // Mostly frames cut from a live rule so the table scan gets exercised,
  // then fixed-case frames, rule rewrites and plain noise.
  function automatic request_t random_request();
    int          pick;
    rule_t       r;
    logic [7:0]  pr;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] sip;
    logic [31:0] dip;
    logic        iface;
    pick = $urandom_range(0, 99);
    if (pick < 12) return random_rule(4'($urandom));
    if (pick < 62) begin
      r     = steer_rules[$urandom_range(0, RULE_SLOTS - 1)];
      pr    = (r.proto == PROTO_TCP || r.proto == PROTO_UDP) ? r.proto :
              ($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP);
      sp    = (r.sport != 16'd0) ? r.sport : pool_port();
      dp    = (r.dport != 16'd0) ? r.dport : pool_port();
      sip   = r.sip;
      dip   = r.dip;
      iface = r.iface;
      // Knock one field off now and then to reach later slots or the default.
      if ($urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 5))
          0:       iface = ~iface;
          1:       sip = pool_ip();
          2:       dip = pool_ip();
          3:       sp = pool_port();
          4:       dp = pool_port();
          default: pr = (pr == PROTO_TCP) ? PROTO_UDP : PROTO_TCP;
        endcase
      end
      return make_frame(ETH_IPV4, pr, sp, dp, sip, dip, iface, 8'($urandom));
    end
    if (pick < 85) begin
      pr    = ($urandom_range(0, 3) != 0) ? PROTO_UDP : PROTO_TCP;
      iface = 1'($urandom);
      case ($urandom_range(0, 7))
        0: return make_frame(ETH_ARP, 8'($urandom), 16'($urandom), 16'($urandom),
                             pool_ip(), pool_ip(), iface, 8'($urandom));
        1: return make_frame(ETH_IPV4, PROTO_ICMP, 16'($urandom), 16'($urandom),
                             pool_ip(), pool_ip(), iface,
                             $urandom_range(0, 1) ? ICMP_ECHO_REQ : 8'($urandom));
        2: return make_frame(ETH_IPV6, 8'($urandom), 16'($urandom), 16'($urandom),
                             $urandom, $urandom, iface, 8'($urandom));
        3: return make_frame(ETH_IPV4, pr, PORT_DNS, pool_port(), pool_ip(), pool_ip(),
                             iface, 8'($urandom));
        4: return make_frame(ETH_IPV4, pr, PORT_DHCP_SRV, pool_port(), pool_ip(),
                             pool_ip(), iface, 8'($urandom));
        5: return make_frame(ETH_IPV4, pr, PORT_DHCP_CLI, pool_port(), pool_ip(),
                             pool_ip(), iface, 8'($urandom));
        6: return make_frame(ETH_IPV4, pr, $urandom_range(0, 1) ? 16'd0 : pool_port(),
                             16'd0, pool_ip(), pool_ip(), iface, 8'($urandom));
        default: return make_frame(ETH_IPV4, 8'($urandom), pool_port(), pool_port(),
                                   pool_ip(), pool_ip(), iface, 8'($urandom));
      endcase
    end
    return make_frame($urandom_range(0, 1) ? ETH_IPV4 : 16'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom), $urandom, $urandom, 1'($urandom),
                      8'($urandom));
  endfunction

  // ---------------------------------------------------------------------
  // Bus drivers
  // ---------------------------------------------------------------------

  // Present one request and hold it until taken, then update the shadow
  // state and optionally idle for a random stretch.
  task automatic send_request(request_t q);
    int gap;
    start            <= 1'b1;
    command_i        <= q.command;
    rule_slot_i      <= q.rule_slot;
    rule_mask_i      <= q.rule_mask;
    rule_direction_i <= q.rule_direction;
    ethertype_i      <= q.ethertype;
    ip_proto_i       <= q.ip_proto;
    l4_sport_i       <= q.l4_sport;
    l4_dport_i       <= q.l4_dport;
    src_ip_i         <= q.src_ip;
    dst_ip_i         <= q.dst_ip;
    rx_iface_i       <= q.rx_iface;
    icmp_kind_i      <= q.icmp_kind;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (q.command == CMD_RULE_WRITE) begin
      steer_rules[q.rule_slot] = '{mask: q.rule_mask, dir: q.rule_direction,
                                   iface: q.rx_iface, proto: q.ip_proto,
                                   sport: q.l4_sport, dport: q.l4_dport,
                                   sip: q.src_ip, dip: q.dst_ip};
      rules_sent++;
    end else begin
      pending_verdicts.push_back(steer_frame(q));
      frames_sent++;
    end
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start, wait for every owed result, then let a trailing rule write
  // or scan settle before the next register access.
  task automatic drain_pipeline();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One APB setup and access phase; the caller releases psel afterwards,
  // so back-to-back transfers never toggle psel within a step.
  task automatic apb_transfer(input logic wr, input logic [2:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    apb_transfer(1'b1, idx, value, readback);
    case (idx)
      REG_DEFAULT_DIR: steer_cfg.default_dir  = value[1:0];
      REG_HOST_READY:  steer_cfg.host_ready   = value[0];
      REG_BRIDGE_MODE: steer_cfg.bridge_mode  = value[0];
      REG_RULES_USED:  steer_cfg.rules_in_use = value[4:0];
      REG_STA_PORT:    steer_cfg.sta_port     = value[0];
      REG_AP_PORT:     steer_cfg.ap_port      = value[0];
      default: ;
    endcase
    apb_transfer(1'b0, idx, 32'd0, readback);
    if (readback !== register_value(idx))
      note_mismatch($sformatf("register %0d read back %0h, expected %0h",
                              idx, readback, register_value(idx)));
  endtask

  // Reprogram every register once the block has gone quiet.
  task automatic program_steering(input logic [1:0] dflt, input logic hready,
                                  input logic bridge, input logic [4:0] used,
                                  input logic sta, input logic ap);
    drain_pipeline();
    write_register(REG_DEFAULT_DIR, {30'd0, dflt});
    write_register(REG_HOST_READY,  {31'd0, hready});
    write_register(REG_BRIDGE_MODE, {31'd0, bridge});
    write_register(REG_RULES_USED,  {27'd0, used});
    write_register(REG_STA_PORT,    {31'd0, sta});
    write_register(REG_AP_PORT,     {31'd0, ap});
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Result checker: the block cannot be stalled, so take every strobe.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : verdict_checker
    verdict_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch($sformatf("unexpected result direction=%0d rule_hit=%0b hit_slot=%0d",
                                direction_o, rule_hit_o, hit_slot_o));
      end else begin
        want = pending_verdicts.pop_front();
        if (direction_o !== want.dir)
          note_mismatch($sformatf("direction expected %0d got %0d", want.dir, direction_o));
        if (rule_hit_o !== want.hit)
          note_mismatch($sformatf("rule_hit expected %0b got %0b", want.hit, rule_hit_o));
        if (hit_slot_o !== want.slot)
          note_mismatch($sformatf("hit_slot expected %0d got %0d", want.slot, hit_slot_o));
        if (rule_hit_o === 1'b1) hits_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Read back reset values; with bridge mode on and the host not ready,
  // everything but IPv6 goes up.
  task automatic check_reset_state();
    logic [31:0] got;
    for (int i = REG_DEFAULT_DIR; i <= REG_AP_PORT; i++) begin
      apb_transfer(1'b0, 3'(i), 32'd0, got);
      if (got !== register_value(3'(i)))
        note_mismatch($sformatf("register %0d reset value %0h, expected %0h",
                                i, got, register_value(3'(i))));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    send_request(make_frame(ETH_IPV4, PROTO_UDP, 16'd1000, 16'd2000,
                            32'h0A00_0001, 32'h0A00_0002, 1'b0, 8'd0));
    send_request(make_frame(ETH_ARP, 8'd0, 16'd0, 16'd0,
                            32'h0A00_0001, 32'h0A00_0002, 1'b1, 8'd0));
    send_request(make_frame(ETH_IPV6, PROTO_TCP, 16'd80, 16'd80,
                            32'h0, 32'h0, 1'b0, 8'd0));
  endtask

  // Walk each hard-wired steering case with the rule table out of play.
  task automatic check_fixed_steering();
    program_steering(DIR_DISCARD, 1'b1, 1'b0, 5'd0, 1'b0, 1'b1);
    send_request(make_frame(ETH_IPV6, PROTO_UDP, 16'd53, 16'd53,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF));
    send_request(make_frame(ETH_ARP, 8'hFF, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 8'd8));
    send_request(make_frame(ETH_IPV4, PROTO_ICMP, 16'd0, 16'd0,
                            32'hC0A8_0101, 32'hC0A8_0102, 1'b0, ICMP_ECHO_REQ));
    send_request(make_frame(ETH_IPV4, PROTO_ICMP, 16'd7, 16'd7,
                            32'hC0A8_0101, 32'hC0A8_0102, 1'b1, 8'hFF));
    send_request(make_frame(ETH_IPV4, PROTO_TCP, 16'd0, 16'hFFFF,
                            32'hC0A8_0101, 32'hC0A8_0102, 1'b0, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_UDP, 16'hFFFF, 16'd0,
                            32'hC0A8_0101, 32'hC0A8_0102, 1'b1, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_UDP, PORT_DNS, 16'd5353,
                            32'h0808_0808, 32'hC0A8_0102, 1'b0, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_TCP, PORT_DNS, 16'd5353,
                            32'h0808_0808, 32'hC0A8_0102, 1'b0, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_UDP, PORT_DHCP_SRV, PORT_DHCP_CLI,
                            32'hC0A8_0101, 32'hFFFF_FFFF, 1'b0, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_UDP, PORT_DHCP_SRV, PORT_DHCP_CLI,
                            32'hC0A8_0101, 32'hFFFF_FFFF, 1'b1, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_UDP, PORT_DHCP_CLI, PORT_DHCP_SRV,
                            32'h0, 32'hFFFF_FFFF, 1'b1, 8'd0));
    send_request(make_frame(16'hFFFF, PROTO_UDP, 16'd1, 16'd1,
                            32'h1, 32'h1, 1'b0, 8'd0));
    send_request(make_frame(ETH_IPV4, 8'hFF, 16'd1, 16'd1,
                            32'h1, 32'h1, 1'b0, 8'd0));
    // Swap the roles: DHCP now lands on the other interfaces.
    program_steering(DIR_HOST, 1'b1, 1'b0, 5'd0, 1'b1, 1'b0);
    send_request(make_frame(ETH_IPV4, PROTO_UDP, PORT_DHCP_SRV, PORT_DHCP_CLI,
                            32'hC0A8_0101, 32'hFFFF_FFFF, 1'b1, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_UDP, PORT_DHCP_CLI, PORT_DHCP_SRV,
                            32'h0, 32'hFFFF_FFFF, 1'b0, 8'd0));
  endtask

  // Lowest slot wins, a full mask needs every field, an empty mask catches
  // all, and a short rule count falls through to the default.
  task automatic check_rule_priority();
    logic [5:0] port_mask;
    port_mask = 6'((1 << MASK_IFACE) | (1 << MASK_PROTO) | (1 << MASK_DPORT));
    send_request(make_rule(4'd0, port_mask, DIR_HOST, PROTO_TCP, 16'd1, 16'd8080,
                           32'h0, 32'h0, 1'b1));
    send_request(make_rule(4'd1, MASK_ALL, DIR_DISCARD, PROTO_UDP, 16'hFFFF, 16'hFFFF,
                           32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
    send_request(make_rule(4'd2, MASK_NONE, DIR_BOTH, 8'd0, 16'd0, 16'd0,
                           32'h0, 32'h0, 1'b0));
    program_steering(DIR_UP, 1'b1, 1'b0, 5'd3, 1'b0, 1'b1);
    send_request(make_frame(ETH_IPV4, PROTO_TCP, 16'd4000, 16'd8080,
                            32'h0A00_0005, 32'h0A00_0006, 1'b1, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_TCP, 16'd4000, 16'd8080,
                            32'h0A00_0005, 32'h0A00_0006, 1'b0, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_UDP, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_UDP, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 32'h0000_0002, 1'b0, 8'd0));
    // Bridge mode is moot while the host is ready; slot 2 is out of use.
    program_steering(DIR_BOTH, 1'b1, 1'b1, 5'd2, 1'b0, 1'b1);
    send_request(make_frame(ETH_IPV4, PROTO_UDP, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF, 32'h0000_0002, 1'b0, 8'd0));
    send_request(make_frame(ETH_IPV4, PROTO_TCP, 16'd4000, 16'd8080,
                            32'h0A00_0005, 32'h0A00_0006, 1'b1, 8'd0));
    program_steering(DIR_DISCARD, 1'b1, 1'b0, 5'd0, 1'b0, 1'b1);
    send_request(make_frame(ETH_IPV4, PROTO_TCP, 16'd4000, 16'd8080,
                            32'h0A00_0005, 32'h0A00_0006, 1'b1, 8'd0));
  endtask

  // Fill the whole table, then run phases of random traffic under changing
  // settings and sender idle rates.
  task automatic check_random_traffic();
    logic [4:0] used;
    for (int s = 0; s < RULE_SLOTS; s++) send_request(random_rule(4'(s)));
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      sender_idle_pct = (phase < 4) ? 32 : (phase < 8) ? 65 : 0;
      case (phase % 4)
        0:       used = 5'd16;
        1:       used = 5'd31;
        2:       used = (phase == 2) ? 5'd0 : 5'($urandom_range(0, 31));
        default: used = 5'($urandom_range(1, 15));
      endcase
      program_steering((phase < 4) ? 2'(phase) : 2'($urandom),
                       $urandom_range(0, 4) != 0, 1'($urandom), used,
                       1'($urandom), 1'($urandom));
      repeat (PHASE_REQUESTS) send_request(random_request());
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 32;
    check_reset_state();
    check_fixed_steering();
    check_rule_priority();
    check_random_traffic();
    drain_pipeline();
    if (pending_verdicts.size() != 0) begin
      $display("%0d frames never got a result", pending_verdicts.size());
      mismatches += pending_verdicts.size();
    end
    $display("covered %0d frames (%0d rule hits) and %0d rule writes",
             frames_sent, hits_seen, rules_sent);
    $display("across %0d register settings at sender idle rates of 32, 65 and 0 percent",
             settings_used);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
